// ----- hdl/smm_pkg.sv -----
package smm_pkg;

  localparam int DATA_W      = 32;
  localparam int DIM_W       = 7;
  localparam int OP_W        = 2;
  localparam int MAX_DIM_DEF = 64;

  // Item kinds carried on in_tuser; code 3 is dropped without effect.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_FETCH  = 2'd2
  } op_t;

endpackage

// ----- hdl/smm_ram.sv -----
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/square_matrix_multiply_int32_core.sv -----
// Signed 32-bit square matrix multiplier. Transfers with in_tuser = 0 store the
// next element of A, transfers with in_tuser = 1 the next element of B, both in
// row-major order with a position counter each that wraps after dim*dim
// elements. A transfer with in_tuser = 2 returns the next element of C = A * B
// in row-major order on out_tdata, with out_tlast high on element dim*dim-1;
// products and sums wrap to 32 bits. Code 3 is taken and dropped. A and B live
// in two simple dual-port RAMs of MAX_DIM*MAX_DIM words; they need no clearing
// pass, and reading an element never loaded gives an arbitrary result. Writing
// dim (0 counts as 1, values above MAX_DIM saturate) clears all three position
// counters and keeps the stored elements. A load is taken at once when idle. A
// fetch holds off new items until its element reaches the output register:
// one multiply-accumulate per cycle, fed by one read of each RAM per cycle,
// through the RAM read, multiply and accumulate stages. The element then waits
// there, so new items are taken while it is still pending downstream.
module square_matrix_multiply_int32_core import smm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write: dim
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIM_W-1:0]         cfg_data,    // [6:0] dim
  // input items
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic signed [DATA_W-1:0] in_tdata,    // [31:0] value
  input  logic [OP_W-1:0]          in_tuser,    // [1:0] op
  // result items
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic signed [DATA_W-1:0] out_tdata,   // [31:0] product
  output logic                     out_tlast
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int N_W    = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r;
  logic [N_W-1:0]      side_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ADDR_W-1:0]   a_pos_r, b_pos_r, c_pos_r;
  logic [N_W-1:0]      c_col_r;
  logic [N_W-1:0]      issue_cnt_r;
  logic                rd_vld_r, rd_last_r;
  logic                prod_vld_r, prod_last_r;
  logic                out_tvalid_r;

  logic [ADDR_W-1:0]   a_addr_r, b_addr_r;
  logic [DATA_W-1:0]   prod_r, acc_r;
  logic                last_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_last_r;

  logic [N_W-1:0]      side_cfg;
  logic [SIZE_W-1:0]   size_cfg;
  logic                in_accept;
  logic                wr_en_a, wr_en_b, fetch_go;
  logic [SIZE_W-1:0]   a_inc, b_inc, c_inc;
  logic                c_wrap;
  logic [ADDR_W-1:0]   a_pos_nxt, b_pos_nxt, c_pos_nxt;
  logic [N_W-1:0]      c_col_nxt;
  logic                rd_en;
  logic                out_free;
  logic [DATA_W-1:0]   a_q, b_q;
  logic [DATA_W-1:0]   mul_lo;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;

  // Side length as the datapath sees it: zero means one, saturate at the top.
  always_comb begin
    if (cfg_data == '0) begin
      side_cfg = N_W'(1);
    end else if (int'(cfg_data) > MAX_DIM) begin
      side_cfg = N_W'(MAX_DIM);
    end else begin
      side_cfg = N_W'(cfg_data);
    end
    size_cfg = SIZE_W'(side_cfg) * SIZE_W'(side_cfg);
  end

  always_comb begin
    wr_en_a  = 1'b0;
    wr_en_b  = 1'b0;
    fetch_go = 1'b0;
    case (op_t'(in_tuser))
      OP_LOAD_A: wr_en_a  = in_accept;
      OP_LOAD_B: wr_en_b  = in_accept;
      OP_FETCH:  fetch_go = in_accept;
      default: ;
    endcase
  end

  // Position advance with wrap at dim*dim; C also tracks its column.
  always_comb begin
    a_inc     = SIZE_W'(a_pos_r) + SIZE_W'(1);
    b_inc     = SIZE_W'(b_pos_r) + SIZE_W'(1);
    c_inc     = SIZE_W'(c_pos_r) + SIZE_W'(1);
    c_wrap    = (c_inc >= size_r);
    a_pos_nxt = (a_inc >= size_r) ? '0 : ADDR_W'(a_inc);
    b_pos_nxt = (b_inc >= size_r) ? '0 : ADDR_W'(b_inc);
    c_pos_nxt = c_wrap ? '0 : ADDR_W'(c_inc);
    if (c_wrap || (c_col_r + N_W'(1) == side_r)) begin
      c_col_nxt = '0;
    end else begin
      c_col_nxt = c_col_r + N_W'(1);
    end
  end

  assign rd_en    = (state_r == S_RUN) && (issue_cnt_r != '0);
  assign out_free = !out_tvalid_r || out_tready;

  smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (a_pos_r),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (a_addr_r),
    .rd_data (a_q)
  );

  smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (b_pos_r),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (b_addr_r),
    .rd_data (b_q)
  );

  // The wrapped sum only needs the low word of each product.
  assign mul_lo = a_q * b_q;

  // Control: counters, sequencing, pipeline valids and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      side_r       <= N_W'(1);
      size_r       <= SIZE_W'(1);
      a_pos_r      <= '0;
      b_pos_r      <= '0;
      c_pos_r      <= '0;
      c_col_r      <= '0;
      issue_cnt_r  <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      prod_vld_r   <= 1'b0;
      prod_last_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        side_r  <= side_cfg;
        size_r  <= size_cfg;
        a_pos_r <= '0;
        b_pos_r <= '0;
        c_pos_r <= '0;
        c_col_r <= '0;
      end else begin
        if (wr_en_a) begin
          a_pos_r <= a_pos_nxt;
        end
        if (wr_en_b) begin
          b_pos_r <= b_pos_nxt;
        end
        if (fetch_go) begin
          c_pos_r     <= c_pos_nxt;
          c_col_r     <= c_col_nxt;
          issue_cnt_r <= side_r;
          state_r     <= S_RUN;
        end
      end

      if (rd_en) begin
        issue_cnt_r <= issue_cnt_r - N_W'(1);
      end
      rd_vld_r    <= rd_en;
      rd_last_r   <= rd_en && (issue_cnt_r == N_W'(1));
      prod_vld_r  <= rd_vld_r;
      prod_last_r <= rd_vld_r && rd_last_r;

      // Final product accumulates on this edge; the sum is ready next cycle.
      if (prod_last_r) begin
        state_r <= S_DONE;
      end

      // Hold the finished sum until the output register is free.
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
        state_r      <= S_IDLE;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath: read addresses, multiply, accumulate, output register.
  always_ff @(posedge clk) begin
    if (fetch_go) begin
      acc_r    <= '0;
      a_addr_r <= c_pos_r - ADDR_W'(c_col_r);
      b_addr_r <= ADDR_W'(c_col_r);
      last_r   <= c_wrap;
    end
    if (rd_en) begin
      a_addr_r <= a_addr_r + ADDR_W'(1);
      b_addr_r <= b_addr_r + ADDR_W'(side_r);
    end
    if (rd_vld_r) begin
      prod_r <= mul_lo;
    end
    if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= acc_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !(wr_en_a || wr_en_b))
    else $error("store read overlaps a load");

  a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_cnt_r != '0) |-> (state_r == S_RUN))
    else $error("reads pending outside the run state");

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    prod_last_r |-> prod_vld_r)
    else $error("final product flag without a product");

  a_drained_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!rd_vld_r && !prod_vld_r))
    else $error("result taken before the pipeline drained");

  a_c_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SIZE_W'(c_pos_r) < size_r) && (c_col_r < side_r))
    else $error("C position outside the matrix");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import smm_pkg::*;

  localparam int MAX_SIDE        = MAX_DIM_DEF;
  localparam int STORE_DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int RANDOM_ITEMS    = 1000;
  // leave room for the longest fetch and for the output stage too
  localparam int SETTLE_CYCLES   = MAX_SIDE + 16;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int LIMIT_CYCLES    = 1_000_000;

  // code 3 has no enum member: the block takes it and drops it
  localparam logic [OP_W-1:0]   OP_IGNORED = 2'd3;
  localparam logic [DATA_W-1:0] INT32_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT32_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic              last;
  } c_elem_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic signed [DATA_W-1:0] in_tdata = '0;     // [31:0] value
  logic [OP_W-1:0]          in_tuser = '0;     // [1:0] op
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic signed [DATA_W-1:0] out_tdata;         // [31:0] product
  logic                     out_tlast;

  square_matrix_multiply_int32_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the block: both stores, which entries hold data, the three
  // position counters and the side length register.
  logic [DATA_W-1:0] a_store [STORE_DEPTH];
  logic [DATA_W-1:0] b_store [STORE_DEPTH];
  bit                a_loaded [STORE_DEPTH];
  bit                b_loaded [STORE_DEPTH];
  int unsigned       a_pos, b_pos, c_pos;
  logic [DIM_W-1:0]  dim_reg = 7'd1;

  c_elem_t     c_expected [$];
  int unsigned accepted_items = 0;
  int unsigned fail_count = 0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  bit          gaps_enabled = 1'b1;
  bit          strays_on = 1'b0;
  bit          hold_off_req = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Give up on a hung run; the limit is several times the slowest legal run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("square_matrix_multiply_int32_core regression: fail");
    $finish;
  end

  // Effective side length: zero counts as one, anything above the build
  // maximum saturates.
  function automatic int unsigned side_now();
    if (dim_reg == '0) return 1;
    if (dim_reg > MAX_SIDE) return MAX_SIDE;
    return int'(dim_reg);
  endfunction

  function automatic void apply_dim(input logic [DIM_W-1:0] d);
    dim_reg = d;
    a_pos = 0;
    b_pos = 0;
    c_pos = 0;
  endfunction

  // True when the next C element reads only entries that were loaded.
  // Fetches that touch never-written entries must not be issued.
  function automatic bit fetch_ready();
    int unsigned n, pos, row, col;
    n = side_now();
    pos = (c_pos >= n * n) ? 0 : c_pos;
    row = pos / n;
    col = pos % n;
    for (int unsigned k = 0; k < n; k++) begin
      if (!a_loaded[row * n + k] || !b_loaded[k * n + col]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow state by one accepted transfer; a fetch queues the
  // C element it must return.
  function automatic void predict_transfer(input logic [OP_W-1:0] op,
                                           input logic [DATA_W-1:0] value);
    int unsigned n, size, row, col;
    c_elem_t elem;
    n = side_now();
    size = n * n;
    case (op)
      OP_LOAD_A: begin
        if (a_pos >= size) a_pos = 0;
        a_store[a_pos] = value;
        a_loaded[a_pos] = 1'b1;
        a_pos = (a_pos + 1 >= size) ? 0 : a_pos + 1;
      end
      OP_LOAD_B: begin
        if (b_pos >= size) b_pos = 0;
        b_store[b_pos] = value;
        b_loaded[b_pos] = 1'b1;
        b_pos = (b_pos + 1 >= size) ? 0 : b_pos + 1;
      end
      OP_FETCH: begin
        if (c_pos >= size) c_pos = 0;
        row = c_pos / n;
        col = c_pos % n;
        elem.product = '0;
        // 32-bit context keeps only the low word of each product and sum
        for (int unsigned k = 0; k < n; k++)
          elem.product += a_store[row * n + k] * b_store[k * n + col];
        elem.last = (c_pos == size - 1);
        c_expected.push_back(elem);
        c_pos = (c_pos + 1 >= size) ? 0 : c_pos + 1;
      end
      default: ;
    endcase
    if (op != OP_IGNORED) accepted_items++;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return INT32_MIN;
      1:       return INT32_MAX;
      2:       return '0;
      3:       return ALL_ONES;
      4:       return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // into the next call, so back-to-back items never drop it for a cycle.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_enabled ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_transfer(op, value);
  endtask

  task automatic stray_item();
    if (strays_on && $urandom_range(0, 19) == 0) send_item(OP_IGNORED, $urandom());
  endtask

  task automatic load_run(input logic [OP_W-1:0] op, input int unsigned count);
    repeat (count) begin
      stray_item();
      send_item(op, rand_value());
    end
  endtask

  task automatic fetch_run(input int unsigned count);
    repeat (count) begin
      stray_item();
      send_item(OP_FETCH, $urandom());
    end
  endtask

  // Drop valid, drain every outstanding C element, then let a trailing
  // load or dropped item work its way through.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (c_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input logic [DIM_W-1:0] d);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_dim(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: switch between always ready, coin flip, mostly stalled and
  // long on/off runs. A hold-off request stalls it flat for a long stretch.
  initial begin
    int unsigned mode, seg_left, run_left;
    bit run_level;
    seg_left = 0;
    run_left = 0;
    run_level = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(50, 300);
        end
        seg_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (run_left == 0) begin
              run_level = ~run_level;
              run_left = $urandom_range(1, 12);
            end
            run_left--;
            out_tready <= run_level;
          end
        endcase
      end
    end
  end

  // Compare each C transfer against the oldest prediction.
  always @(posedge clk) begin
    c_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (c_expected.size() == 0) begin
        $display("%0t: unexpected result, got product %0d last %0b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = c_expected.pop_front();
        if (out_tdata !== want.product) begin
          $display("%0t: product mismatch, expected %0d, got %0d",
                   $time, $signed(want.product), out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Out of reset the side length is one: a single load of each matrix
  // makes C available.
  task automatic test_reset_side();
    send_item(OP_LOAD_A, 32'd7);
    send_item(OP_LOAD_B, ALL_ONES);
    send_item(OP_FETCH, '0);
  endtask

  // Extreme operands on a 2x2, dropped items between loads, then wrap the
  // C counter and the A counter.
  task automatic test_extremes();
    write_dim(7'd2);
    send_item(OP_LOAD_A, INT32_MIN);
    send_item(OP_LOAD_A, INT32_MAX);
    send_item(OP_IGNORED, ALL_ONES);
    send_item(OP_LOAD_A, ALL_ONES);
    send_item(OP_LOAD_A, 32'd1);
    send_item(OP_LOAD_B, INT32_MIN);
    send_item(OP_LOAD_B, ALL_ONES);
    send_item(OP_IGNORED, '0);
    send_item(OP_LOAD_B, INT32_MAX);
    send_item(OP_LOAD_B, 32'd2);
    fetch_run(5);
    send_item(OP_LOAD_A, '0);
    fetch_run(1);
  endtask

  // Side length written as zero behaves as one; every C element is last.
  task automatic test_dim_zero();
    write_dim(7'd0);
    send_item(OP_LOAD_A, INT32_MIN);
    send_item(OP_LOAD_B, INT32_MIN);
    send_item(OP_IGNORED, INT32_MAX);
    fetch_run(2);
  endtask

  // Stall the result side for a long stretch while fetches keep coming, so
  // the output register fills and the input side backs up.
  task automatic test_backpressure();
    write_dim(7'd4);
    load_run(OP_LOAD_A, 16);
    load_run(OP_LOAD_B, 16);
    gaps_enabled = 1'b0;
    hold_off_req = 1'b1;
    fetch_run(16);
    gaps_enabled = 1'b1;
  endtask

  // Random phases: mostly full load-then-fetch sequences with random data
  // and stray dropped items, the rest free mixes that stop anywhere.
  task automatic test_random_traffic();
    int unsigned start_count, n, size, mix_len, pick;
    logic [OP_W-1:0] op;
    start_count = accepted_items;
    strays_on = 1'b1;
    while (accepted_items - start_count < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      size = n * n;
      write_dim(7'(n));
      gaps_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1)) begin
          load_run(OP_LOAD_A, size);
          load_run(OP_LOAD_B, size);
        end else begin
          load_run(OP_LOAD_B, size);
          load_run(OP_LOAD_A, size);
        end
        fetch_run(size + $urandom_range(0, n));
      end else begin
        mix_len = $urandom_range(size, 4 * size + 4);
        repeat (mix_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) op = OP_LOAD_A;
          else if (pick < 6) op = OP_LOAD_B;
          else if (pick < 9) op = OP_FETCH;
          else op = OP_IGNORED;
          // turn a fetch that would read unloaded entries into a load
          if (op == OP_FETCH && !fetch_ready()) op = pick[0] ? OP_LOAD_B : OP_LOAD_A;
          send_item(op, rand_value());
        end
      end
    end
    strays_on = 1'b0;
    gaps_enabled = 1'b1;
  endtask

  initial begin
    a_pos = 0;
    b_pos = 0;
    c_pos = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_side();
    test_extremes();
    test_dim_zero();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("square_matrix_multiply_int32_core regression: pass");
    end else begin
      $display("square_matrix_multiply_int32_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/smm_pkg.sv
hdl/smm_ram.sv
hdl/square_matrix_multiply_int32_core.sv
bench/tb.sv
